@@ src/integer_to_ascii_formatter_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the integer to ASCII formatter
// Define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition a implies condition b in the same cycle
`define ITOA_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("itoa assertion failed");

// Condition a implies condition b in the next cycle
`define ITOA_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("itoa assertion failed");

`else

`define ITOA_ASSERT_IMPLY(label, clk, rst, a, b)
`define ITOA_ASSERT_NEXT(label, clk, rst, a, b)

`endif

`endif

@@ src/itoa_pkg.sv @@
// ----------------------------------------------------------------------------
// itoa_pkg
// Character codes and the digit-to-ASCII mapping of the formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package itoa_pkg;

  // ASCII codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_HEX_A = 8'h41;

  // First digit value that prints as a letter
  localparam logic [3:0] HEX_LETTER_MIN = 4'd10;

  // Shift-and-add-3 correction for BCD digits
  localparam logic [3:0] BCD_ADJUST_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJUST     = 4'd3;

  // One digit (0..15) to its uppercase ASCII character
  function automatic logic [7:0] ascii_digit(input logic [3:0] d);
    logic [7:0] ext;
    ext = {4'h0, d};
    if (d < HEX_LETTER_MIN) begin
      return CHAR_ZERO + ext;
    end else begin
      return CHAR_HEX_A + ext - {4'h0, HEX_LETTER_MIN};
    end
  endfunction

endpackage

`default_nettype wire

@@ src/integer_to_ascii_formatter.sv @@
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Prints one word as signed decimal or uppercase hex, one character a beat.
// ----------------------------------------------------------------------------
// Input channel: value/kind with in_valid/in_ready. kind 0 reads value as
// signed decimal, kind 1 as unsigned hex. Output channel: character/last with
// out_valid/out_ready, most significant character first, last set on the
// final character. Negative decimals start with '-'; leading zeros are
// dropped and zero prints as a single '0'.
// Decimal conversion is bit-serial shift-and-add-3: one input bit per cycle,
// into NumDigits BCD digits. Hex loads the digits directly. The digit
// register is then shifted out one digit per cycle while leading zeros are
// skipped, then one character per cycle while the receiver keeps taking them.
// in_ready is high only while idle; the next item can be taken while the
// final character still waits in the output register.
// Reset returns to idle and drops any pending character. A stalled receiver
// holds the output register and the character output simply waits.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_formatter #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [VALUE_WIDTH-1:0] value,
  input  wire logic                   kind,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  output logic [7:0]                  character,
  output logic                        last,
  output logic                        out_valid,
  input  wire logic                   out_ready
);
  import itoa_pkg::*;

  `include "integer_to_ascii_formatter_macros.svh"

  // Decimal digits needed for 2**VALUE_WIDTH - 1 (always covers hex too)
  localparam int NumDigits = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int DigW      = 4 * NumDigits;
  localparam int BitCntW   = $clog2(VALUE_WIDTH + 1);
  localparam int SlotCntW  = $clog2(NumDigits + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_SKIP,
    ST_EMIT
  } state_t;

  state_t                 state;
  logic [VALUE_WIDTH-1:0] bin;
  logic [DigW-1:0]        digits;
  logic [DigW-1:0]        digits_next;
  logic [BitCntW-1:0]     bit_cnt;
  logic [SlotCntW-1:0]    slot_cnt;
  logic                   neg;

  logic                   in_neg;
  logic [VALUE_WIDTH-1:0] in_mag;
  logic [3:0]             top_digit;
  logic                   out_load;
  logic                   char_load;

  assign in_ready  = (state == ST_IDLE);
  assign top_digit = digits[DigW-1 -: 4];
  assign out_load  = !out_valid || out_ready;
  // a new character enters the output register this cycle
  assign char_load = out_load && (state == ST_SIGN || state == ST_EMIT);

  // Sign and magnitude; the most negative value comes out as 2**(W-1)
  assign in_neg = !kind && value[VALUE_WIDTH-1];
  assign in_mag = in_neg ? (~value + 1'b1) : value;

  // One double-dabble step: correct each digit, then shift in a bit
  always_comb begin
    logic [DigW-1:0] adj;
    adj = digits;
    for (int i = 0; i < NumDigits; i++) begin
      if (digits[4*i +: 4] >= BCD_ADJUST_MIN) begin
        adj[4*i +: 4] = digits[4*i +: 4] + BCD_ADJUST;
      end
    end
    digits_next = {adj[DigW-2:0], bin[VALUE_WIDTH-1]};
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      neg       <= 1'b0;
      bit_cnt   <= '0;
      slot_cnt  <= '0;
    end else begin
      if (out_ready && !char_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            neg      <= in_neg;
            slot_cnt <= SlotCntW'(NumDigits);
            if (kind) begin
              digits <= DigW'(in_mag);
              state  <= ST_SKIP;
            end else begin
              bin     <= in_mag;
              digits  <= '0;
              bit_cnt <= BitCntW'(VALUE_WIDTH);
              state   <= ST_CONV;
            end
          end
        end
        ST_CONV: begin
          digits  <= digits_next;
          bin     <= bin << 1;
          bit_cnt <= bit_cnt - 1'b1;
          if (bit_cnt == BitCntW'(1)) begin
            state <= neg ? ST_SIGN : ST_SKIP;
          end
        end
        ST_SIGN: begin
          if (out_load) begin
            character <= CHAR_MINUS;
            last      <= 1'b0;
            out_valid <= 1'b1;
            state     <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          // drop leading zeros, keeping at least one digit
          if (top_digit == 4'h0 && slot_cnt > SlotCntW'(1)) begin
            digits   <= {digits[DigW-5:0], 4'h0};
            slot_cnt <= slot_cnt - 1'b1;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            character <= ascii_digit(top_digit);
            last      <= (slot_cnt == SlotCntW'(1));
            out_valid <= 1'b1;
            digits    <= {digits[DigW-5:0], 4'h0};
            slot_cnt  <= slot_cnt - 1'b1;
            if (slot_cnt == SlotCntW'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks
  `ITOA_ASSERT_IMPLY(a_sign_only_negative, clk, rst, state == ST_SIGN, neg)
  `ITOA_ASSERT_IMPLY(a_conv_count_live, clk, rst, state == ST_CONV, bit_cnt != '0)
  `ITOA_ASSERT_IMPLY(a_emit_slot_live, clk, rst, state == ST_EMIT, slot_cnt != '0)
  `ITOA_ASSERT_IMPLY(a_minus_not_last, clk, rst,
                     out_valid && character == CHAR_MINUS, !last)
  `ITOA_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, in_valid && in_ready, !in_ready)

endmodule

`default_nettype wire
